>>> design/sch_pkg.sv
// Package for the sorted color histogram: sizes, codes, entry and
// transaction types, and the pixel color mask function. No dependencies.
`default_nettype none

package sch_pkg;

   localparam int unsigned SCH_MAX_COLORS      = 1024;
   localparam int unsigned SCH_MAX_PIXEL_BYTES = 4;
   localparam int unsigned SCH_IDX_W           = $clog2(SCH_MAX_COLORS);
   localparam int unsigned SCH_TOT_W           = $clog2(SCH_MAX_COLORS + 1);
   localparam int unsigned SCH_USED_W          = 11;
   localparam int unsigned SCH_COLOR_W         = 32;
   localparam int unsigned SCH_COUNT_W         = 32;
   localparam int unsigned SCH_BPP_W           = 3;
   localparam int unsigned SCH_KIND_W          = 2;
   localparam int unsigned SCH_RANK_W          = 10;
   localparam int unsigned SCH_STATUS_W        = 3;

   localparam logic [SCH_BPP_W-1:0] SCH_BPP_RESET = SCH_BPP_W'(3);

   typedef enum logic [SCH_KIND_W-1:0] {
      KIND_COUNT,
      KIND_READ,
      KIND_CLEAR,
      KIND_NONE
   } sch_kind_type;

   typedef enum logic [SCH_STATUS_W-1:0] {
      ST_EXISTING,
      ST_NEW,
      ST_DROPPED,
      ST_READ_OK,
      ST_PAST_END,
      ST_CLEARED
   } sch_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_CHECK,
      S_SHIFT,
      S_MOVE,
      S_RANK,
      S_DONE
   } sch_state_type;

   typedef struct packed {
      logic [SCH_COLOR_W-1:0] color;
      logic [SCH_COUNT_W-1:0] count;
   } sch_entry_type;

   typedef struct packed {
      logic [SCH_KIND_W-1:0]  kind;
      logic [SCH_COLOR_W-1:0] color;
      logic [SCH_RANK_W-1:0]  rank;
   } sch_req_type;

   typedef struct packed {
      sch_status_type         status;
      logic [SCH_COLOR_W-1:0] color;
      logic [SCH_COUNT_W-1:0] count;
   } sch_res_type;

   // Mask of the pixel bytes; byte count clamped to 1..min(MAX_PIXEL_BYTES, 4).
   function automatic logic [SCH_COLOR_W-1:0] sch_color_mask(
      input logic [SCH_BPP_W-1:0] bpp
   );
      logic [SCH_BPP_W-1:0] n;
      n = bpp;
      if (n == '0) n = SCH_BPP_W'(1);
      if (n > SCH_BPP_W'(SCH_MAX_PIXEL_BYTES)) n = SCH_BPP_W'(SCH_MAX_PIXEL_BYTES);
      if (n > SCH_BPP_W'(4)) n = SCH_BPP_W'(4);
      unique case (n)
         SCH_BPP_W'(1): return 32'h0000_00FF;
         SCH_BPP_W'(2): return 32'h0000_FFFF;
         SCH_BPP_W'(3): return 32'h00FF_FFFF;
         default:       return 32'hFFFF_FFFF;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> design/sch_req_if.sv
// Request channel interface (valid/ready plus request payload).
// Depends on sch_pkg for field widths.
`default_nettype none

interface sch_req_if;
   import sch_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SCH_KIND_W-1:0]  kind;
   logic [SCH_COLOR_W-1:0] pixel_color;
   logic [SCH_RANK_W-1:0]  rank;

   modport source (output valid, kind, pixel_color, rank, input ready);
   modport sink (input valid, kind, pixel_color, rank, output ready);
   modport monitor (input valid, ready, kind, pixel_color, rank);
endinterface

`default_nettype wire

>>> design/sch_rsp_if.sv
// Response channel interface (valid/ready plus response payload).
// Depends on sch_pkg for field widths.
`default_nettype none

interface sch_rsp_if;
   import sch_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SCH_STATUS_W-1:0] status;
   logic [SCH_COLOR_W-1:0]  color_out;
   logic [SCH_COUNT_W-1:0]  count_out;
   logic [SCH_USED_W-1:0]   entries_used;

   modport source (output valid, status, color_out, count_out, entries_used, input ready);
   modport sink (input valid, status, color_out, count_out, entries_used, output ready);
   modport monitor (input valid, ready, status, color_out, count_out, entries_used);
endinterface

`default_nettype wire

>>> design/sorted_color_histogram.sv
// Sorted color histogram, top level. A count request binary-searches the stored colors;
//   a known color has its count raised, and for a new color every entry above its slot
//   shifts up. Read by rank returns one entry, clear empties the table. One transaction at
//   a time: the search loop and the insertion shift over the entry RAM set the rate.
// Reset (synchronous, active high) empties the table and sets the pixel byte count to 3.
// Depends on sch_pkg, sch_req_if, sch_rsp_if and sch_seq.
`default_nettype none

module sorted_color_histogram (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sch_req_if.sink                            req_ch,
   sch_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [sch_pkg::SCH_BPP_W-1:0] csr_wdata
);
   import sch_pkg::*;

   logic [SCH_BPP_W-1:0]    bpp_ff;
   logic                    seq_idle, seq_done, take, req_accept;
   sch_req_type             req;
   sch_res_type             res;
   logic [SCH_TOT_W-1:0]    total;

   logic                    rsp_valid_ff;
   sch_res_type             rsp_res_ff;
   logic [SCH_USED_W-1:0]   rsp_used_ff;

   // config register: bytes per pixel, clamped at use
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= SCH_BPP_RESET;
      end else if (csr_we) begin
         bpp_ff <= csr_wdata;
      end
   end

   // new transaction only while the sequencer rests; an unread response does not block
   assign req_ch.ready = seq_idle;
   assign req_accept   = req_ch.valid && seq_idle;
   assign req          = '{req_ch.kind, req_ch.pixel_color, req_ch.rank};

   sch_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .req   (req),
      .bpp   (bpp_ff),
      .take  (take),
      .idle  (seq_idle),
      .done  (seq_done),
      .res   (res),
      .total (total)
   );

   // result moves to the output register once it is empty or being drained
   assign take = seq_done && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         rsp_res_ff  <= res;
         rsp_used_ff <= SCH_USED_W'(total);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_res_ff.status;
   assign rsp_ch.color_out    = rsp_res_ff.color;
   assign rsp_ch.count_out    = rsp_res_ff.count;
   assign rsp_ch.entries_used = rsp_used_ff;
endmodule

`default_nettype wire

>>> design/sch_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sch_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

>>> design/sch_seq.sv
// Sequencer and datapath: binary search, count update, insertion shift,
// rank read and clear over the entry RAM. Depends on sch_pkg and sch_ram.
`default_nettype none

module sch_seq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire sch_pkg::sch_req_type           req,
   input  wire logic [sch_pkg::SCH_BPP_W-1:0]  bpp,
   input  wire logic                           take,
   output logic                                idle,
   output logic                                done,
   output sch_pkg::sch_res_type                res,
   output logic [sch_pkg::SCH_TOT_W-1:0]       total
);
   import sch_pkg::*;

   sch_state_type           state_ff, state_in;
   logic [SCH_COLOR_W-1:0]  color_ff, color_in;
   logic [SCH_TOT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [SCH_TOT_W-1:0]    total_ff, total_in;
   sch_res_type             res_ff, res_in;

   logic [SCH_TOT_W:0]      mid_sum;
   logic [SCH_TOT_W-1:0]    mid;
   logic                    lo_lt_hi, hit, full, rank_ok;
   logic                    cmp_lt, cmp_eq;
   logic [SCH_COUNT_W-1:0]  cnt_inc;

   logic                    wr_en;
   logic [SCH_IDX_W-1:0]    wr_addr, rd_addr;
   sch_entry_type           wr_data, rd_data;

   function automatic logic [SCH_IDX_W-1:0] idx_in_minus_one(
      input logic [SCH_TOT_W-1:0] v
   );
      logic [SCH_TOT_W-1:0] d;
      d = v - 1'b1;
      return d[SCH_IDX_W-1:0];
   endfunction

   sch_ram #(
      .WIDTH ($bits(sch_entry_type)),
      .DEPTH (SCH_MAX_COLORS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare unit against the masked request color
   assign cmp_lt   = rd_data.color < color_ff;
   assign cmp_eq   = rd_data.color == color_ff;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[SCH_TOT_W:1];
   assign lo_lt_hi = lo_ff < hi_ff;
   assign hit      = (lo_ff < total_ff) && cmp_eq;
   assign full     = total_ff >= SCH_TOT_W'(SCH_MAX_COLORS);
   assign rank_ok  = idx_ff < total_ff;
   assign cnt_inc  = (rd_data.count == '1) ? rd_data.count : rd_data.count + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (sch_kind_type'(req.kind))
                  KIND_COUNT: state_in = S_SEARCH;
                  KIND_READ:  state_in = S_RANK;
                  KIND_CLEAR: state_in = S_DONE;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_SEARCH:  state_in = lo_lt_hi ? S_COMPARE : S_CHECK;
         S_COMPARE: state_in = S_SEARCH;
         S_CHECK:   state_in = (hit || full) ? S_DONE : S_SHIFT;
         S_SHIFT:   state_in = (idx_ff == lo_ff) ? S_DONE : S_MOVE;
         S_MOVE:    state_in = S_SHIFT;
         S_RANK:    state_in = S_DONE;
         S_DONE:    state_in = take ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      color_in = color_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               color_in = req.color & sch_color_mask(bpp);
               lo_in    = '0;
               hi_in    = total_ff;
               idx_in   = SCH_TOT_W'(req.rank);
               if (sch_kind_type'(req.kind) == KIND_CLEAR) begin
                  total_in = '0;
                  res_in   = '{ST_CLEARED, '0, '0};
               end
            end
         end
         S_COMPARE: begin
            if (cmp_lt) lo_in = mid + 1'b1;
            else        hi_in = mid;
         end
         S_CHECK: begin
            idx_in = total_ff;
            if (hit)       res_in = '{ST_EXISTING, color_ff, cnt_inc};
            else if (full) res_in = '{ST_DROPPED, color_ff, '0};
         end
         S_SHIFT: begin
            if (idx_ff == lo_ff) begin
               total_in = total_ff + 1'b1;
               res_in   = '{ST_NEW, color_ff, SCH_COUNT_W'(1)};
            end
         end
         S_MOVE: idx_in = idx_ff - 1'b1;
         S_RANK: begin
            if (rank_ok) res_in = '{ST_READ_OK, rd_data.color, rd_data.count};
            else         res_in = '{ST_PAST_END, '0, '0};
         end
         default: ;
      endcase
   end

   // RAM control and handshake outputs
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lo_ff[SCH_IDX_W-1:0];
      wr_data = '{color_ff, cnt_inc};
      rd_addr = req.rank;
      unique case (state_ff)
         S_SEARCH: rd_addr = lo_lt_hi ? mid[SCH_IDX_W-1:0] : lo_ff[SCH_IDX_W-1:0];
         S_CHECK:  wr_en   = hit;
         S_SHIFT: begin
            rd_addr = idx_in_minus_one(idx_ff);
            if (idx_ff == lo_ff) begin
               wr_en   = 1'b1;
               wr_data = '{color_ff, SCH_COUNT_W'(1)};
            end
         end
         S_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[SCH_IDX_W-1:0];
            wr_data = rd_data;
         end
         default: ;
      endcase
   end

   assign idle  = state_ff == S_IDLE;
   assign done  = state_ff == S_DONE;
   assign res   = res_ff;
   assign total = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
      color_ff <= color_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      idx_ff   <= idx_in;
      res_ff   <= res_in;
   end
endmodule

`default_nettype wire

>>> design/sch_checker.sv
// Port-level checker for the sorted color histogram, bound to the top level.
// Depends on sch_pkg, sch_req_if and sch_rsp_if.
`default_nettype none

module sch_checker (
   input wire logic  clock,
   input wire logic  reset,
   sch_req_if.sink   req_ch,
   sch_rsp_if.source rsp_ch
);
   import sch_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.status)
         && $stable(rsp_ch.color_out) && $stable(rsp_ch.count_out)
         && $stable(rsp_ch.entries_used))
      else $error("response changed while stalled");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.entries_used <= SCH_USED_W'(SCH_MAX_COLORS))
      else $error("entries_used above table size");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_CLEARED |->
         rsp_ch.entries_used == '0 && rsp_ch.color_out == '0 && rsp_ch.count_out == '0)
      else $error("clear response not empty");

   a_new: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_NEW |->
         rsp_ch.count_out == SCH_COUNT_W'(1) && rsp_ch.entries_used != '0)
      else $error("new entry response inconsistent");

   a_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_DROPPED |->
         rsp_ch.count_out == '0 && rsp_ch.entries_used == SCH_USED_W'(SCH_MAX_COLORS))
      else $error("drop reported with free table space");
endmodule

bind sorted_color_histogram sch_checker u_sch_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

`default_nettype wire
